FILE: rtl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants for the binary max-heap queue: command and
// status codes, controller states and the beats passed between level cells.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int KEY_W     = 32;
  localparam int CNT_OUT_W = 11;

  // item command
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  // result status
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_FWAIT,
    S_RUN,
    S_RESP
  } state_t;

  // downward beat: a key travelling towards the leaves
  typedef struct packed {
    logic             valid;
    cmd_t             op;
    logic [KEY_W-1:0] key;
  } tok_t;

  // upward write: key for the node that the upper cell last sent down from
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } wb_t;

endpackage

FILE: rtl/bmhq_cell.sv
// ----------------------------------------------------------------------------
// bmhq_cell
// One heap level. Holds the 2**LEVEL nodes of its level in a local memory,
// takes a key beat from the level above, decides with its own read data and
// hands the key on to the level below or writes it back up.
// ----------------------------------------------------------------------------
module bmhq_cell #(
  parameter int LEVEL = 1,
  parameter int W     = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bmhq_pkg::tok_t            tok_in,
  input  logic [W-1:0]              ofs_in,
  output bmhq_pkg::tok_t            tok_out,
  output logic [W-1:0]              ofs_out,
  input  bmhq_pkg::wb_t             wb_in,
  output bmhq_pkg::wb_t             wb_out,
  input  logic                      fetch,
  input  logic [W-1:0]              path,
  input  logic [$clog2(W)-1:0]      tgt,
  input  logic [W-1:0]              cnt,
  input  logic [bmhq_pkg::KEY_W-1:0] fdat_in,
  output logic [bmhq_pkg::KEY_W-1:0] fdat_out,
  input  logic                      done_in,
  output logic                      done_out
);

  localparam int TW = $clog2(W);
  localparam int AW = LEVEL;
  localparam logic [W-1:0] BASE = W'(2 ** LEVEL);

  logic [bmhq_pkg::KEY_W-1:0] mem [2 ** LEVEL];
  logic [bmhq_pkg::KEY_W-1:0] rd_a, rd_b;

  logic                       pend;
  bmhq_pkg::cmd_t             op_r;
  logic [bmhq_pkg::KEY_W-1:0] key_r;
  logic [W-1:0]               pofs_r;
  logic [AW-1:0]              och_r;
  logic                       fet_r;

  logic [AW-1:0]              own_ofs;
  logic                       here;
  logic                       ins_here;
  logic                       is_sift;
  logic [AW-1:0]              addr_a, addr_b;

  logic                       lgt, r_ok, c_r, sw_rem, deeper, ins_gt;
  logic [bmhq_pkg::KEY_W-1:0] c_key;
  logic [W-1:0]               l_idx, ch_idx;
  logic [AW-1:0]              ch_ofs;
  logic                       fin;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [bmhq_pkg::KEY_W-1:0] wdata;

  // node on the insert / fetch path at this level
  assign own_ofs  = path[W-2 -: AW];
  assign here     = (tgt == TW'(LEVEL));
  assign ins_here = tok_in.valid && (tok_in.op == bmhq_pkg::CMD_INSERT) && here;
  assign is_sift  = tok_in.valid && (tok_in.op == bmhq_pkg::CMD_REMOVE);

  // read addresses: sibling pair under the parent, else the path node
  assign addr_a = is_sift ? AW'({ofs_in, 1'b0}) : own_ofs;
  assign addr_b = AW'({ofs_in, 1'b1});

  // sift-down decision on the registered children
  assign lgt    = $signed(rd_a) > $signed(rd_b);
  assign l_idx  = BASE | W'({pofs_r, 1'b0});
  assign r_ok   = l_idx < cnt;
  assign c_r    = r_ok && !lgt;
  assign c_key  = c_r ? rd_b : rd_a;
  assign sw_rem = $signed(c_key) > $signed(key_r);
  assign ch_ofs = AW'({pofs_r, c_r});
  assign ch_idx = BASE | W'(ch_ofs);
  assign deeper = ch_idx <= (cnt >> 1);

  // insert decision: larger key stays, smaller moves on
  assign ins_gt = $signed(key_r) > $signed(rd_a);

  // beats to the neighbours
  always_comb begin
    tok_out = '0;
    ofs_out = '0;
    wb_out  = '0;
    fin     = ins_here;
    if (pend && (op_r == bmhq_pkg::CMD_INSERT)) begin
      tok_out.valid = 1'b1;
      tok_out.op    = bmhq_pkg::CMD_INSERT;
      tok_out.key   = ins_gt ? rd_a : key_r;
    end else if (pend) begin
      wb_out.valid = 1'b1;
      wb_out.key   = sw_rem ? c_key : key_r;
      if (sw_rem && deeper) begin
        tok_out.valid = 1'b1;
        tok_out.op    = bmhq_pkg::CMD_REMOVE;
        tok_out.key   = key_r;
        ofs_out       = W'(ch_ofs);
      end else begin
        fin = 1'b1;
      end
    end
  end

  // single write port
  always_comb begin
    we    = 1'b0;
    waddr = own_ofs;
    wdata = tok_in.key;
    if (ins_here) begin
      we = 1'b1;
    end else if (pend && (op_r == bmhq_pkg::CMD_INSERT)) begin
      we    = ins_gt;
      wdata = key_r;
    end else if (pend && sw_rem && !deeper) begin
      we    = 1'b1;
      waddr = ch_ofs;
      wdata = key_r;
    end else if (wb_in.valid) begin
      we    = 1'b1;
      waddr = och_r;
      wdata = wb_in.key;
    end
  end

  // level memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  // beat capture
  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= 1'b0;
      fet_r <= 1'b0;
    end else begin
      pend  <= tok_in.valid && !ins_here;
      fet_r <= fetch && here;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      op_r   <= tok_in.op;
      key_r  <= tok_in.key;
      pofs_r <= ofs_in;
    end
    if (pend && (op_r == bmhq_pkg::CMD_REMOVE)) begin
      och_r <= ch_ofs;
    end
  end

  // gathered chains towards the controller
  assign fdat_out = fet_r ? rd_a : fdat_in;
  assign done_out = fin | done_in;

endmodule

FILE: rtl/binary_max_heap_queue_top.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue_top
// Max-heap priority queue built as a row of level cells below a root register.
// An insert walks its key down towards the free slot's level; a removal
// first fetches the last entry (S_FETCH, S_FWAIT), then sifts it down.
// A new item is accepted only in idle, once the last result is loaded into
// the outputs; the key walks one heap level per cycle down the cell row.
// Reset clears the count and the handshake state; the node memories keep
// their contents and need no clearing pass.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_top #(
  parameter int CAPACITY = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic signed [bmhq_pkg::KEY_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bmhq_pkg::KEY_W-1:0] removed_value,
  output logic signed [bmhq_pkg::KEY_W-1:0] top_value,
  output logic                              top_valid,
  output logic [bmhq_pkg::CNT_OUT_W-1:0]    entry_count,
  output logic [1:0]                        status
);

  localparam int W  = $clog2(CAPACITY + 1);
  localparam int TW = $clog2(W);
  localparam logic [W-1:0] CAP = W'(CAPACITY);

  bmhq_pkg::state_t           state, state_next;
  logic [W-1:0]               count;
  logic [bmhq_pkg::KEY_W-1:0] root;
  logic [bmhq_pkg::KEY_W-1:0] removed_r;
  bmhq_pkg::stat_t            status_r;
  bmhq_pkg::tok_t             tok0;
  bmhq_pkg::tok_t             tok0_next;
  logic [W-1:0]               path_r;
  logic [TW-1:0]              tgt_r;
  logic                       fetch_r;

  logic                       acc;
  logic                       ld_out;
  logic [W-1:0]               idx_c, path_c;
  logic [TW-1:0]              lvl_c;

  bmhq_pkg::tok_t             tok  [1:W];
  logic [W-1:0]               ofs  [1:W];
  bmhq_pkg::wb_t              wb   [0:W-1];
  logic [bmhq_pkg::KEY_W-1:0] fdat [1:W];
  logic                       done [1:W];

  // position of the leading one
  function automatic logic [TW-1:0] msb_pos(input logic [W-1:0] x);
    logic [TW-1:0] p;
    p = '0;
    for (int k = 0; k < W; k++) begin
      if (x[k]) p = TW'(k);
    end
    return p;
  endfunction

  assign acc = in_valid && in_ready;

  // 1-based node index of the insert slot or the last entry, left aligned
  assign idx_c  = (command == bmhq_pkg::CMD_INSERT) ? count + 1'b1 : count;
  assign lvl_c  = msb_pos(idx_c);
  assign path_c = idx_c << (TW'(W - 1) - lvl_c);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bmhq_pkg::S_IDLE: begin
        if (acc) begin
          if (command == bmhq_pkg::CMD_INSERT) begin
            state_next = (count == CAP || count == '0) ? bmhq_pkg::S_RESP
                                                       : bmhq_pkg::S_RUN;
          end else begin
            state_next = (count <= W'(1)) ? bmhq_pkg::S_RESP : bmhq_pkg::S_FETCH;
          end
        end
      end
      bmhq_pkg::S_FETCH: state_next = bmhq_pkg::S_FWAIT;
      bmhq_pkg::S_FWAIT: begin
        state_next = (count == W'(1)) ? bmhq_pkg::S_RESP : bmhq_pkg::S_RUN;
      end
      bmhq_pkg::S_RUN: begin
        if (done[1]) state_next = bmhq_pkg::S_RESP;
      end
      bmhq_pkg::S_RESP: begin
        if (!out_valid || out_ready) state_next = bmhq_pkg::S_IDLE;
      end
      default: state_next = bmhq_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    ld_out   = 1'b0;
    case (state)
      bmhq_pkg::S_IDLE: in_ready = 1'b1;
      bmhq_pkg::S_RESP: ld_out   = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
        ld_out   = 1'b0;
      end
    endcase
  end

  // beat into the first cell: insert carry or the fetched last entry
  always_comb begin
    tok0_next = '0;
    if (acc && (command == bmhq_pkg::CMD_INSERT) && count != CAP && count != '0) begin
      tok0_next.valid = 1'b1;
      tok0_next.op    = bmhq_pkg::CMD_INSERT;
      tok0_next.key   = ($signed(value) > $signed(root)) ? root : value;
    end else if (state == bmhq_pkg::S_FWAIT && count != W'(1)) begin
      tok0_next.valid = 1'b1;
      tok0_next.op    = bmhq_pkg::CMD_REMOVE;
      tok0_next.key   = fdat[1];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bmhq_pkg::S_IDLE;
      count     <= '0;
      tok0      <= '0;
      fetch_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      tok0    <= tok0_next;
      fetch_r <= acc && (command == bmhq_pkg::CMD_REMOVE) && (count > W'(1));
      if (acc) begin
        if (command == bmhq_pkg::CMD_INSERT) begin
          if (count != CAP) count <= count + 1'b1;
        end else if (count != '0) begin
          count <= count - 1'b1;
        end
      end
      if (ld_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // root and result payload
  always_ff @(posedge clk) begin
    if (acc) begin
      removed_r <= (command == bmhq_pkg::CMD_REMOVE && count != '0) ? root : '0;
      path_r    <= path_c;
      tgt_r     <= lvl_c;
      if (command == bmhq_pkg::CMD_INSERT) begin
        status_r <= (count == CAP) ? bmhq_pkg::STAT_FULL : bmhq_pkg::STAT_OK;
        if (count != CAP && (count == '0 || $signed(value) > $signed(root))) begin
          root <= value;
        end
      end else begin
        status_r <= (count == '0) ? bmhq_pkg::STAT_EMPTY : bmhq_pkg::STAT_OK;
      end
    end
    // last entry lands in the root when it is the only one left
    if (state == bmhq_pkg::S_FWAIT && count == W'(1)) begin
      root <= fdat[1];
    end
    if (wb[0].valid) begin
      root <= wb[0].key;
    end
    if (ld_out) begin
      removed_value <= removed_r;
      top_value     <= (count != '0) ? root : '0;
      top_valid     <= (count != '0);
      entry_count   <= bmhq_pkg::CNT_OUT_W'(count);
      status        <= status_r;
    end
  end

  // level cell row
  assign tok[1]    = tok0;
  assign ofs[1]    = '0;
  assign wb[W-1]   = '0;
  assign fdat[W]   = '0;
  assign done[W]   = 1'b0;

  for (genvar j = 1; j < W; j++) begin : g_lvl
    bmhq_cell #(
      .LEVEL (j),
      .W     (W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (tok[j]),
      .ofs_in   (ofs[j]),
      .tok_out  (tok[j+1]),
      .ofs_out  (ofs[j+1]),
      .wb_in    (wb[j]),
      .wb_out   (wb[j-1]),
      .fetch    (fetch_r),
      .path     (path_r),
      .tgt      (tgt_r),
      .cnt      (count),
      .fdat_in  (fdat[j+1]),
      .fdat_out (fdat[j]),
      .done_in  (done[j+1]),
      .done_out (done[j])
    );
  end

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    count <= CAP)
    else $error("stored count above capacity");

  a_done_run: assert property (@(posedge clk) disable iff (rst)
    done[1] |-> state == bmhq_pkg::S_RUN)
    else $error("cell row finished outside a run");

  a_root_wb: assert property (@(posedge clk) disable iff (rst)
    wb[0].valid |-> state == bmhq_pkg::S_RUN)
    else $error("root write-back outside a run");

  a_rem_cnt: assert property (@(posedge clk) disable iff (rst)
    acc && command == bmhq_pkg::CMD_REMOVE && count != '0
      |=> count == $past(count) - 1'b1)
    else $error("removal did not shrink the heap");

endmodule
